// ===== hw/rtl/ast_pkg.sv =====
// Shared types and constants for the assembler source tokenizer.
// Holds the result record, the push bundle between lexer and result queue,
// and the token kind codes. No dependencies.
package ast_pkg;

  localparam int unsigned OffsetW   = 16;
  localparam int unsigned SpanW     = 16;
  localparam int unsigned ValueW    = 63;
  localparam int unsigned KindW     = 4;
  localparam int unsigned FifoDepth = 4;

  localparam logic [KindW-1:0] KindEnd     = 4'd0;
  localparam logic [KindW-1:0] KindNewline = 4'd1;
  localparam logic [KindW-1:0] KindIdent   = 4'd2;
  localparam logic [KindW-1:0] KindNumber  = 4'd3;
  localparam logic [KindW-1:0] KindPlus    = 4'd4;
  localparam logic [KindW-1:0] KindMinus   = 4'd5;
  localparam logic [KindW-1:0] KindStar    = 4'd6;
  localparam logic [KindW-1:0] KindLparen  = 4'd7;
  localparam logic [KindW-1:0] KindRparen  = 4'd8;
  localparam logic [KindW-1:0] KindComma   = 4'd9;
  localparam logic [KindW-1:0] KindSemi    = 4'd10;
  localparam logic [KindW-1:0] KindLbrace  = 4'd11;
  localparam logic [KindW-1:0] KindRbrace  = 4'd12;
  localparam logic [KindW-1:0] KindColon   = 4'd13;
  localparam logic [KindW-1:0] KindDollar  = 4'd14;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [SpanW-1:0]  span_start;
    logic [SpanW-1:0]  span_end;
    logic [ValueW-1:0] value;
    logic              error;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ===== hw/rtl/assembler_source_tokenizer.sv =====
// Top level of the assembler source tokenizer: lexer core and result queue.
// Depends on ast_pkg, ast_lexer and ast_res_fifo.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   char_byte_i
//   out      output     out_valid_o / out_stall_i token_kind_o, span_start_o, span_end_o,
//                                                 number_value_o, error_flag_o, last_of_run_o
//
// One source byte is taken per cycle unless the input stalls; its results enter a four-entry
// queue in the same cycle. A byte that closes one token and opens another yields two results,
// which drain one per cycle while the output is not stalled. Input stalls while fewer than two
// queue slots are free, so a long run of two-result bytes is paced by the single output port.
// Reset clears the scanner state, the offset counter and the queue; no clearing pass is needed.
module assembler_source_tokenizer import ast_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        char_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [KindW-1:0]  token_kind_o,
  output logic [SpanW-1:0]  span_start_o,
  output logic [SpanW-1:0]  span_end_o,
  output logic [ValueW-1:0] number_value_o,
  output logic              error_flag_o,
  output logic              last_of_run_o
);

  logic  accept, pop, full;
  push_t push;
  res_t  head;

  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;
  assign pop        = out_valid_o && !out_stall_i;

  ast_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_byte_i (char_byte_i),
    .push_o      (push)
  );

  ast_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (out_valid_o),
    .full_o  (full)
  );

  assign token_kind_o   = head.kind;
  assign span_start_o   = head.span_start;
  assign span_end_o     = head.span_end;
  assign number_value_o = head.value;
  assign error_flag_o   = head.error;
  assign last_of_run_o  = head.last;

endmodule

// ===== hw/rtl/ast_lexer.sv =====
// Tokenizer state machine and number accumulator: one source byte per request.
// Emits up to two compacted results per byte towards the result queue.
// Depends on ast_pkg.
module ast_lexer import ast_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_byte_i,
  output push_t      push_o
);

  localparam logic [3:0] MIdle      = 4'd0;
  localparam logic [3:0] MCr        = 4'd1;
  localparam logic [3:0] MSlash     = 4'd2;
  localparam logic [3:0] MLine      = 4'd3;
  localparam logic [3:0] MBlock     = 4'd4;
  localparam logic [3:0] MBlockStar = 4'd5;
  localparam logic [3:0] MIdent     = 4'd6;
  localparam logic [3:0] MZero      = 4'd7;
  localparam logic [3:0] MNum       = 4'd8;
  localparam logic [3:0] MDone      = 4'd9;

  localparam logic [4:0] Base2  = 5'd2;
  localparam logic [4:0] Base8  = 5'd8;
  localparam logic [4:0] Base10 = 5'd10;
  localparam logic [4:0] Base16 = 5'd16;
  localparam logic [4:0] NoDigit = 5'd31;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChVt    = 8'h0b;
  localparam logic [7:0] ChFf    = 8'h0c;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChUnder = 8'h5f;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowB  = 8'h62;
  localparam logic [7:0] ChUpB   = 8'h42;

  localparam int unsigned ProdW = ValueW + 5;
  localparam logic [OffsetW-1:0] OffsetMax = '1;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = NoDigit;
    if (c >= ChZero && c <= ChNine) begin
      d = 5'(c - ChZero);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 5'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 5'(c - 8'h41 + 8'd10);
    end
    return d;
  endfunction

  function automatic logic [KindW-1:0] punct_kind(input logic [7:0] c);
    logic [KindW-1:0] k;
    unique case (c)
      8'h2b:   k = KindPlus;
      8'h2d:   k = KindMinus;
      8'h2a:   k = KindStar;
      8'h28:   k = KindLparen;
      8'h29:   k = KindRparen;
      8'h2c:   k = KindComma;
      8'h3b:   k = KindSemi;
      8'h7b:   k = KindLbrace;
      8'h7d:   k = KindRbrace;
      8'h3a:   k = KindColon;
      8'h24:   k = KindDollar;
      default: k = KindEnd;
    endcase
    return k;
  endfunction

  function automatic res_t mk_res(input logic [KindW-1:0] kind, input logic [OffsetW-1:0] s,
                                  input logic [OffsetW-1:0] e, input logic [ValueW-1:0] v,
                                  input logic err);
    res_t r;
    r.kind       = kind;
    r.span_start = SpanW'(s);
    r.span_end   = SpanW'(e);
    r.value      = v;
    r.error      = err;
    r.last       = 1'b0;
    return r;
  endfunction

  logic [3:0]         mode_q, mode_d;
  logic [OffsetW-1:0] offset_q, offset_d;
  logic [OffsetW-1:0] begin_q, begin_d;
  logic [ValueW-1:0]  acc_q, acc_d;
  logic [4:0]         base_q, base_d;
  logic               dseen_q, dseen_d;
  logic               bad_q, bad_d;

  logic [OffsetW-1:0] pos, nxt;
  logic [4:0]         dig;
  logic               word;
  logic [ProdW-1:0]   prod;
  logic               do_idle, do_num, dseen_eff;
  logic               a_v, b_v;
  res_t               a_res, b_res;
  push_t              push;

  assign pos  = offset_q;
  assign nxt  = (offset_q == OffsetMax) ? offset_q : offset_q + OffsetW'(1);
  assign dig  = digit_of(char_byte_i);
  assign word = is_alpha(char_byte_i) || is_digit(char_byte_i) || char_byte_i == ChUnder;
  assign dseen_eff = dseen_q || (mode_q == MZero);

  always_comb begin
    case (base_q)
      Base2:   prod = ProdW'({acc_q, 1'b0});
      Base8:   prod = ProdW'({acc_q, 3'b000});
      Base16:  prod = ProdW'({acc_q, 4'b0000});
      default: prod = ProdW'({acc_q, 3'b000}) + ProdW'({acc_q, 1'b0});
    endcase
  end

  logic [ProdW-1:0] next_val;
  assign next_val = prod + ProdW'(dig);

  always_comb begin
    mode_d   = mode_q;
    offset_d = offset_q;
    begin_d  = begin_q;
    acc_d    = acc_q;
    base_d   = base_q;
    dseen_d  = dseen_q;
    bad_d    = bad_q;
    do_idle  = 1'b0;
    do_num   = 1'b0;
    a_v      = 1'b0;
    b_v      = 1'b0;
    a_res    = mk_res(KindEnd, pos, pos, '0, 1'b0);
    b_res    = mk_res(KindEnd, pos, pos, '0, 1'b0);

    if (mode_q != MDone) begin
      offset_d = nxt;
    end

    unique case (mode_q)
      MIdle: do_idle = 1'b1;
      MCr: begin
        a_v = 1'b1;
        if (char_byte_i == ChLf) begin
          a_res  = mk_res(KindNewline, begin_q, nxt, '0, 1'b0);
          mode_d = MIdle;
        end else begin
          a_res   = mk_res(KindNewline, begin_q, pos, '0, 1'b0);
          do_idle = 1'b1;
        end
      end
      MSlash: begin
        if (char_byte_i == ChSlash) begin
          mode_d = MLine;
        end else if (char_byte_i == ChStar) begin
          mode_d = MBlock;
        end else begin
          mode_d = MDone;
          a_v    = 1'b1;
          a_res  = mk_res(KindEnd, begin_q, pos, '0, 1'b1);
        end
      end
      MLine: begin
        if (char_byte_i == ChNul || char_byte_i == ChLf || char_byte_i == ChCr) begin
          do_idle = 1'b1;
        end
      end
      MBlock, MBlockStar: begin
        if (char_byte_i == ChNul) begin
          mode_d = MDone;
          a_v    = 1'b1;
          a_res  = mk_res(KindEnd, begin_q, pos, '0, 1'b1);
        end else if (char_byte_i == ChStar) begin
          mode_d = MBlockStar;
        end else if (char_byte_i == ChSlash && mode_q == MBlockStar) begin
          mode_d = MIdle;
        end else begin
          mode_d = MBlock;
        end
      end
      MIdent: begin
        if (!word) begin
          a_v     = 1'b1;
          a_res   = mk_res(KindIdent, begin_q, pos, '0, 1'b0);
          do_idle = 1'b1;
        end
      end
      MZero: begin
        mode_d = MNum;
        if (char_byte_i == ChLowX || char_byte_i == ChUpX) begin
          base_d = Base16;
        end else if (char_byte_i == ChLowB || char_byte_i == ChUpB) begin
          base_d = Base2;
        end else begin
          dseen_d = 1'b1;
          do_num  = 1'b1;
        end
      end
      MNum: do_num = 1'b1;
      MDone: ;
      default: ;
    endcase

    if (do_num) begin
      if (word) begin
        dseen_d = 1'b1;
        if (dig >= base_q) begin
          bad_d = 1'b1;
        end else if (!bad_q) begin
          if (|next_val[ProdW-1:ValueW]) begin
            bad_d = 1'b1;
          end else begin
            acc_d = next_val[ValueW-1:0];
          end
        end
      end else if (bad_q || ((base_q == Base16 || base_q == Base2) && !dseen_eff)) begin
        mode_d = MDone;
        a_v    = 1'b1;
        a_res  = mk_res(KindNumber, begin_q, pos, '0, 1'b1);
      end else begin
        a_v     = 1'b1;
        a_res   = mk_res(KindNumber, begin_q, pos, acc_q, 1'b0);
        do_idle = 1'b1;
      end
    end

    if (do_idle) begin
      mode_d = MIdle;
      if (char_byte_i == ChNul) begin
        mode_d = MDone;
        b_v    = 1'b1;
        b_res  = mk_res(KindEnd, pos, pos, '0, 1'b0);
      end else if (char_byte_i == ChSpace || char_byte_i == ChTab ||
                   char_byte_i == ChVt || char_byte_i == ChFf) begin
        mode_d = MIdle;
      end else if (char_byte_i == ChLf) begin
        b_v   = 1'b1;
        b_res = mk_res(KindNewline, pos, nxt, '0, 1'b0);
      end else begin
        begin_d = pos;
        if (char_byte_i == ChCr) begin
          mode_d = MCr;
        end else if (char_byte_i == ChSlash) begin
          mode_d = MSlash;
        end else if (is_alpha(char_byte_i) || char_byte_i == ChUnder) begin
          mode_d = MIdent;
        end else if (is_digit(char_byte_i)) begin
          bad_d = 1'b0;
          acc_d = ValueW'(char_byte_i - ChZero);
          if (char_byte_i == ChZero) begin
            mode_d  = MZero;
            base_d  = Base8;
            dseen_d = 1'b0;
          end else begin
            mode_d  = MNum;
            base_d  = Base10;
            dseen_d = 1'b1;
          end
        end else if (punct_kind(char_byte_i) != KindEnd) begin
          b_v   = 1'b1;
          b_res = mk_res(punct_kind(char_byte_i), pos, nxt, '0, 1'b0);
        end else begin
          mode_d = MDone;
          b_v    = 1'b1;
          b_res  = mk_res(KindEnd, pos, nxt, '0, 1'b1);
        end
      end
    end
  end

  always_comb begin
    push = '0;
    if (a_v && b_v) begin
      push.count   = 2'd2;
      push.r0      = a_res;
      push.r1      = b_res;
      push.r1.last = 1'b1;
    end else if (a_v) begin
      push.count   = 2'd1;
      push.r0      = a_res;
      push.r0.last = 1'b1;
    end else if (b_v) begin
      push.count   = 2'd1;
      push.r0      = b_res;
      push.r0.last = 1'b1;
    end
    if (!accept_i) begin
      push.count = 2'd0;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MIdle;
      offset_q <= '0;
      begin_q  <= '0;
      acc_q    <= '0;
      base_q   <= Base10;
      dseen_q  <= 1'b0;
      bad_q    <= 1'b0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      offset_q <= offset_d;
      begin_q  <= begin_d;
      acc_q    <= acc_d;
      base_q   <= base_d;
      dseen_q  <= dseen_d;
      bad_q    <= bad_d;
    end
  end

endmodule

// ===== hw/rtl/ast_res_fifo.sv =====
// Small result queue between the lexer and the output channel.
// Takes up to two results a cycle and hands out one. Depends on ast_pkg.
module ast_res_fifo import ast_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  logic  pop_i,
  output res_t  head_o,
  output logic  valid_o,
  output logic  full_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  res_t            entries_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;
  logic [PtrW-1:0] wr_next;

  assign wr_next = wr_q + PtrW'(1);
  assign head_o  = entries_q[rd_q];
  assign valid_o = count_q != '0;
  assign full_o  = count_q > CntW'(FifoDepth - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entries_q[wr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      entries_q[wr_next] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + PtrW'(push_i.count);
      rd_q    <= rd_q + PtrW'(pop_i);
      count_q <= count_q + CntW'(push_i.count) - CntW'(pop_i);
    end
  end

endmodule

// ===== hw/rtl/ast_checker.sv =====
// Port-level checks for the assembler source tokenizer, bound to the top level.
// Depends on ast_pkg and assembler_source_tokenizer.
module ast_checker import ast_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [KindW-1:0]  token_kind_o,
  input logic [SpanW-1:0]  span_start_o,
  input logic [SpanW-1:0]  span_end_o,
  input logic [ValueW-1:0] number_value_o,
  input logic              error_flag_o,
  input logic              last_of_run_o
);

  logic out_acc;
  assign out_acc = out_valid_o && !out_stall_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(span_start_o) && $stable(token_kind_o))
    else $error("stalled request changed");

  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (error_flag_o || token_kind_o == KindEnd) |=> !out_valid_o)
    else $error("request after final token");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_flag_o |-> last_of_run_o)
    else $error("error token not last of its run");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> span_end_o >= span_start_o)
    else $error("span ends before it starts");

  a_value_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && number_value_o != '0 |-> token_kind_o == KindNumber && !error_flag_o)
    else $error("value on a non-number token");

endmodule

bind assembler_source_tokenizer ast_checker u_ast_checker (.*);
